### src/bcfm_pkg.sv
// Shared types, constants and constant functions for the bell-curve membership block.
`default_nettype none
package bcfm_pkg;

    // fixed-point layout
    localparam int FRAC_BITS       = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int LOG_DEPTH       = $clog2(EXP_TABLE_DEPTH);

    // field widths
    localparam int VAL_W  = 32;                 // Q16.16 sample / centre
    localparam int WID_W  = 31;                 // Q15.16 width
    localparam int MEM_W  = 17;                 // Q1.16 membership
    localparam int SAT_SH = 5;                  // ratio limit 32 = 2^5
    localparam int QUO_W  = FRAC_BITS + SAT_SH; // quotient bits
    localparam int SQ_W   = 2 * QUO_W;          // squared ratio
    localparam int Y_W    = 32;                 // Q31 power value
    localparam int N_W    = 5;                  // integer exponent bits kept
    localparam int N_LIMIT = 17;

    localparam logic [MEM_W-1:0] MEM_ONE  = MEM_W'(65536);
    localparam logic [MEM_W-1:0] MEM_ZERO = '0;

    // register indexes
    localparam logic [2:0] REG_CENTRAL_VALUE = 3'd0;
    localparam logic [2:0] REG_CENTRAL_KNOWN = 3'd1;
    localparam logic [2:0] REG_LEFT_WIDTH    = 3'd2;
    localparam logic [2:0] REG_RIGHT_WIDTH   = 3'd3;
    localparam logic [2:0] REG_CURVE_MODE    = 3'd4;

    // curve modes
    localparam logic [1:0] MODE_BELL       = 2'd0;
    localparam logic [1:0] MODE_OPEN_ABOVE = 2'd1;
    localparam logic [1:0] MODE_OPEN_BELOW = 2'd2;

    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(65536000);

    // per-beat flags that ride along the pipeline
    typedef struct packed {
        logic dflt;   // missing sample or unknown centre
        logic one;    // result forced to 1
        logic zero;   // result forced to 0
    } t_side;

    // integer floor square root, 64 bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = '0;
        bt  = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-i) in Q31
    function automatic logic [Y_W-1:0] root_q31(input int i);
        logic [63:0] s;
        s = isqrt64(64'h2000_0000_0000_0000);
        for (int j = 2; j <= FRAC_BITS; j++) begin
            if (j <= i) begin
                s = isqrt64(s << 31);
            end
        end
        return s[Y_W-1:0];
    endfunction

endpackage
`default_nettype wire

### src/bcfm_front.sv
// Front stages: distance from the centre, side selection and special cases.
`default_nettype none
module bcfm_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [bcfm_pkg::VAL_W-1:0]  i_env_value,
    input  wire logic                        i_value_missing,
    input  wire logic [bcfm_pkg::VAL_W-1:0]  i_central_value,
    input  wire logic                        i_central_known,
    input  wire logic [bcfm_pkg::WID_W-1:0]  i_left_width,
    input  wire logic [bcfm_pkg::WID_W-1:0]  i_right_width,
    input  wire logic [1:0]                  i_curve_mode,
    output logic                             o_valid,
    output logic [bcfm_pkg::VAL_W-1:0]       o_a,
    output logic [bcfm_pkg::WID_W-1:0]       o_w,
    output bcfm_pkg::t_side                  o_side
);
    import bcfm_pkg::*;

    // stage 1: signed difference
    logic               r_v1;
    logic               r_dflt1;
    logic [VAL_W:0]     r_d1;

    // stage 2: magnitude and side
    logic               r_v2;
    logic               r_one2;
    logic               r_dflt2;
    logic [VAL_W-1:0]   r_a2;
    logic [WID_W-1:0]   r_w2;

    // stage 3: range check
    logic               r_v3;
    t_side              r_side3;
    logic [VAL_W-1:0]   r_a3;
    logic [WID_W-1:0]   r_w3;

    logic [VAL_W:0]     n_d1;
    logic               n_zero;
    logic               n_above;
    logic               n_open;
    logic [VAL_W:0]     n_neg;
    logic [VAL_W+SAT_SH-1:0] n_lim;

    assign n_d1 = {i_env_value[VAL_W-1], i_env_value}
                - {i_central_value[VAL_W-1], i_central_value};

    assign n_zero  = (r_d1 == '0);
    assign n_above = !r_d1[VAL_W] && !n_zero;
    assign n_open  = ((i_curve_mode == MODE_OPEN_ABOVE) && n_above)
                  || ((i_curve_mode == MODE_OPEN_BELOW) && !n_above);
    assign n_neg   = '0 - r_d1;

    assign n_lim = {{(VAL_W - WID_W){1'b0}}, r_w2, {SAT_SH{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1    <= n_d1;
            r_dflt1 <= i_value_missing || !i_central_known;

            r_dflt2 <= r_dflt1;
            r_one2  <= r_dflt1 || n_zero || n_open;
            r_a2    <= n_above ? r_d1[VAL_W-1:0] : n_neg[VAL_W-1:0];
            r_w2    <= n_above ? i_right_width : i_left_width;

            r_side3.dflt <= r_dflt2;
            r_side3.one  <= r_one2;
            r_side3.zero <= (r_w2 == '0)
                         || ({{SAT_SH{1'b0}}, r_a2} >= n_lim);
            r_a3 <= r_a2;
            r_w3 <= r_w2;
        end
    end

    assign o_valid = r_v3;
    assign o_a     = r_a3;
    assign o_w     = r_w3;
    assign o_side  = r_side3;

endmodule
`default_nettype wire

### src/bcfm_div.sv
// Pipelined restoring divider: ratio (a << FRAC_BITS) / w, one quotient bit per stage.
`default_nettype none
module bcfm_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [bcfm_pkg::VAL_W-1:0]  i_a,
    input  wire logic [bcfm_pkg::WID_W-1:0]  i_w,
    input  bcfm_pkg::t_side                  i_side,
    output logic                             o_valid,
    output logic [bcfm_pkg::QUO_W-1:0]       o_q,
    output bcfm_pkg::t_side                  o_side
);
    import bcfm_pkg::*;

    localparam int NSTG = QUO_W;

    logic               r_v    [NSTG];
    logic [WID_W-1:0]   r_rem  [NSTG];
    logic [QUO_W-1:0]   r_q    [NSTG];
    logic [WID_W-1:0]   r_w    [NSTG];
    logic [SAT_SH-1:0]  r_alo  [NSTG];
    t_side              r_side [NSTG];

    genvar t;
    generate
        for (t = 0; t < NSTG; t++) begin : g_stg
            logic               v_in;
            logic [WID_W-1:0]   rem_in;
            logic [QUO_W-1:0]   q_in;
            logic [WID_W-1:0]   w_in;
            logic [SAT_SH-1:0]  alo_in;
            t_side              side_in;
            logic               nbit;
            logic [WID_W:0]     shf;
            logic               ge;
            logic [WID_W:0]     dif;

            if (t == 0) begin : g_first
                // a < 32*w, so the top bits already lie below w
                assign v_in    = i_valid;
                assign rem_in  = {{(WID_W - VAL_W + SAT_SH){1'b0}}, i_a[VAL_W-1:SAT_SH]};
                assign q_in    = '0;
                assign w_in    = i_w;
                assign alo_in  = i_a[SAT_SH-1:0];
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_v[t-1];
                assign rem_in  = r_rem[t-1];
                assign q_in    = r_q[t-1];
                assign w_in    = r_w[t-1];
                assign alo_in  = r_alo[t-1];
                assign side_in = r_side[t-1];
            end

            // next dividend bit: low bits of a, then the fraction zeros
            if (t < SAT_SH) begin : g_abit
                assign nbit = alo_in[SAT_SH-1-t];
            end else begin : g_zbit
                assign nbit = 1'b0;
            end

            assign shf = {rem_in, nbit};
            assign ge  = (shf >= {1'b0, w_in});
            assign dif = shf - {1'b0, w_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[t] <= 1'b0;
                end else if (i_en) begin
                    r_v[t] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[t]  <= ge ? dif[WID_W-1:0] : shf[WID_W-1:0];
                    r_q[t]    <= {q_in[QUO_W-2:0], ge};
                    r_w[t]    <= w_in;
                    r_alo[t]  <= alo_in;
                    r_side[t] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NSTG-1];
    assign o_q     = r_q[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule
`default_nettype wire

### src/bcfm_exp.sv
// Square of the ratio, power of one half by a chain of root multiplies, rounding and output register.
`default_nettype none
module bcfm_exp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [bcfm_pkg::QUO_W-1:0]  i_q,
    input  bcfm_pkg::t_side                  i_side,
    output logic                             o_valid,
    output logic [bcfm_pkg::MEM_W-1:0]       o_membership,
    output logic                             o_defaulted
);
    import bcfm_pkg::*;

    // square stage
    logic             r_vs;
    logic [SQ_W-1:0]  r_e;
    t_side            r_ss;

    // exponent split stage
    logic                 r_vk;
    logic [LOG_DEPTH-1:0] r_k;
    logic [N_W-1:0]       r_nk;
    t_side                r_sk;

    // root multiply chain
    logic                 r_vm [LOG_DEPTH];
    logic [Y_W-1:0]       r_y  [LOG_DEPTH];
    logic [LOG_DEPTH-1:0] r_km [LOG_DEPTH];
    logic [N_W-1:0]       r_nm [LOG_DEPTH];
    t_side                r_sm [LOG_DEPTH];

    // output register
    logic              r_vo;
    logic [MEM_W-1:0]  r_mem;
    logic              r_dflt;

    logic [SQ_W-2*FRAC_BITS-1:0] n_nfull;
    logic [Y_W:0]                n_sum;
    logic [Y_W:0]                n_shr;

    // r_e is the raw square of the ratio: the exponent is r_e >> FRAC_BITS,
    // so its integer part starts at bit 2*FRAC_BITS
    assign n_nfull = r_e[SQ_W-1:2*FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
            r_vk <= 1'b0;
        end else if (i_en) begin
            r_vs <= i_valid;
            r_vk <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e  <= {{QUO_W{1'b0}}, i_q} * {{QUO_W{1'b0}}, i_q};
            r_ss <= i_side;

            r_k       <= r_e[2*FRAC_BITS-1:2*FRAC_BITS-LOG_DEPTH];
            r_nk      <= r_e[2*FRAC_BITS+N_W-1:2*FRAC_BITS];
            r_sk.dflt <= r_ss.dflt;
            r_sk.one  <= r_ss.one;
            r_sk.zero <= r_ss.zero || (n_nfull >= (SQ_W-2*FRAC_BITS)'(N_LIMIT));
        end
    end

    genvar i;
    generate
        for (i = 0; i < LOG_DEPTH; i++) begin : g_mul
            localparam logic [Y_W-1:0] ROOT = root_q31(i + 1);
            logic                 v_in;
            logic [Y_W-1:0]       y_in;
            logic [LOG_DEPTH-1:0] k_in;
            logic [N_W-1:0]       n_in;
            t_side                s_in;
            logic [2*Y_W-1:0]     prod;

            if (i == 0) begin : g_first
                assign v_in = r_vk;
                assign y_in = Y_W'(64'h8000_0000);
                assign k_in = r_k;
                assign n_in = r_nk;
                assign s_in = r_sk;
            end else begin : g_next
                assign v_in = r_vm[i-1];
                assign y_in = r_y[i-1];
                assign k_in = r_km[i-1];
                assign n_in = r_nm[i-1];
                assign s_in = r_sm[i-1];
            end

            assign prod = {{Y_W{1'b0}}, y_in} * {{Y_W{1'b0}}, ROOT};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vm[i] <= 1'b0;
                end else if (i_en) begin
                    r_vm[i] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[i]  <= k_in[LOG_DEPTH-1-i] ? prod[Y_W+30:31] : y_in;
                    r_km[i] <= k_in;
                    r_nm[i] <= n_in;
                    r_sm[i] <= s_in;
                end
            end
        end
    endgenerate

    // round to Q1.16 with the integer part of the exponent as extra shift
    assign n_sum = {1'b0, r_y[LOG_DEPTH-1]}
                 + ((Y_W+1)'(1) << ((Y_W+1)'(14) + (Y_W+1)'(r_nm[LOG_DEPTH-1])));
    assign n_shr = n_sum >> ((Y_W+1)'(15) + (Y_W+1)'(r_nm[LOG_DEPTH-1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vm[LOG_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dflt <= r_sm[LOG_DEPTH-1].dflt;
            if (r_sm[LOG_DEPTH-1].one) begin
                r_mem <= MEM_ONE;
            end else if (r_sm[LOG_DEPTH-1].zero) begin
                r_mem <= MEM_ZERO;
            end else begin
                r_mem <= n_shr[MEM_W-1:0];
            end
        end
    end

    assign o_valid      = r_vo;
    assign o_membership = r_mem;
    assign o_defaulted  = r_dflt;

endmodule
`default_nettype wire

### src/bell_curve_fuzzy_membership.sv
// Top level: configuration registers, stream ports and the membership pipeline.
//
// Usage: one environmental sample per beat enters on the s_ stream (tdata holds
// the signed Q16.16 value, tuser flags a no-data cell). One result beat leaves on
// the m_ stream for every input beat, in order: tdata holds the Q1.16 membership
// (65536 = 1), tuser flags a result forced to 1 by a missing sample or centre.
// Throughput is one beat per cycle while m_tready does not stall the pipeline.
// From acceptance to m_tvalid a beat passes 3 front stages, 21 divider stages
// (one quotient bit each), the square and split stages, 8 root multiply stages
// (one per table index bit) and the output register.
// The APB port writes centre, centre-known flag, left and right width and curve
// mode; write them only while no beat is in flight.
// Reset clears all pipeline valid bits and loads the register defaults.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module bell_curve_fuzzy_membership (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // sample stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] env_value
    input  wire logic         s_tuser,   // [0] value_missing
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,   // [16:0] membership, [23:17] zero
    output logic              m_tuser,   // [0] defaulted
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bcfm_pkg::*;

    logic [VAL_W-1:0] r_central_value;
    logic             r_central_known;
    logic [WID_W-1:0] r_left_width;
    logic [WID_W-1:0] r_right_width;
    logic [1:0]       r_curve_mode;

    logic [2:0]       n_idx;
    logic             n_wr;
    logic             n_en;

    logic             f_valid;
    logic [VAL_W-1:0] f_a;
    logic [WID_W-1:0] f_w;
    t_side            f_side;

    logic             d_valid;
    logic [QUO_W-1:0] d_q;
    t_side            d_side;

    logic             e_valid;
    logic [MEM_W-1:0] e_mem;
    logic             e_dflt;

    // register file
    assign n_idx  = paddr[4:2];
    assign n_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_central_value <= '0;
            r_central_known <= 1'b0;
            r_left_width    <= WIDTH_RESET;
            r_right_width   <= WIDTH_RESET;
            r_curve_mode    <= MODE_BELL;
        end else if (n_wr) begin
            case (n_idx)
                REG_CENTRAL_VALUE: r_central_value <= pwdata;
                REG_CENTRAL_KNOWN: r_central_known <= pwdata[0];
                REG_LEFT_WIDTH:    r_left_width    <= pwdata[WID_W-1:0];
                REG_RIGHT_WIDTH:   r_right_width   <= pwdata[WID_W-1:0];
                REG_CURVE_MODE:    r_curve_mode    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            REG_CENTRAL_VALUE: prdata = r_central_value;
            REG_CENTRAL_KNOWN: prdata = {31'd0, r_central_known};
            REG_LEFT_WIDTH:    prdata = {1'b0, r_left_width};
            REG_RIGHT_WIDTH:   prdata = {1'b0, r_right_width};
            REG_CURVE_MODE:    prdata = {30'd0, r_curve_mode};
            default:           prdata = '0;
        endcase
    end

    // pipeline advances unless a result waits on a stalled receiver
    assign n_en     = !e_valid || m_tready;
    assign s_tready = n_en;

    bcfm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (n_en),
        .i_valid         (s_tvalid),
        .i_env_value     (s_tdata),
        .i_value_missing (s_tuser),
        .i_central_value (r_central_value),
        .i_central_known (r_central_known),
        .i_left_width    (r_left_width),
        .i_right_width   (r_right_width),
        .i_curve_mode    (r_curve_mode),
        .o_valid         (f_valid),
        .o_a             (f_a),
        .o_w             (f_w),
        .o_side          (f_side)
    );

    bcfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (f_valid),
        .i_a     (f_a),
        .i_w     (f_w),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    bcfm_exp u_exp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (n_en),
        .i_valid      (d_valid),
        .i_q          (d_q),
        .i_side       (d_side),
        .o_valid      (e_valid),
        .o_membership (e_mem),
        .o_defaulted  (e_dflt)
    );

    assign m_tvalid = e_valid;
    assign m_tdata  = {{(24 - MEM_W){1'b0}}, e_mem};
    assign m_tuser  = e_dflt;

endmodule
`default_nettype wire
